[rtl/core/modbus_write_register_framer_unit_macros.svh]
// Assertion macros shared by the Modbus write-register framer RTL.
`ifndef MODBUS_WRITE_REGISTER_FRAMER_UNIT_MACROS_SVH
`define MODBUS_WRITE_REGISTER_FRAMER_UNIT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define MWRF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define MWRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MWRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mwrf_pkg.sv]
// Types, constants and the CRC-16/Modbus byte step for the write-register framer.
`timescale 1ns / 1ps
package mwrf_pkg;

    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  REG_ADDR_HI       = 8'h00;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    // Configuration reset values
    localparam logic [7:0]  VOLTAGE_STATION_RST = 8'd1;
    localparam logic [7:0]  CURRENT_STATION_RST = 8'd2;
    localparam logic [7:0]  REGISTER_BASE_RST   = 8'd21;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLTAGE_STATION = 2'd0,
        CFG_CURRENT_STATION = 2'd1,
        CFG_REGISTER_BASE   = 2'd2
    } t_cfg_idx;

    // Position of the byte being sent within the 8-byte frame
    typedef enum logic [2:0] {
        POS_STATION = 3'd0,
        POS_FUNC    = 3'd1,
        POS_ADDR_HI = 3'd2,
        POS_ADDR_LO = 3'd3,
        POS_VAL_HI  = 3'd4,
        POS_VAL_LO  = 3'd5,
        POS_CRC_LO  = 3'd6,
        POS_CRC_HI  = 3'd7
    } t_frame_pos;

    // Classified request: everything the serializer needs
    typedef struct packed {
        logic [7:0]  station;
        logic [7:0]  reg_addr;
        logic [15:0] value;
    } t_frame_hdr;

    // Queue write side
    typedef struct packed {
        logic       valid;
        t_frame_hdr hdr;
    } t_q_push;

    // One byte into the reflected CRC, eight shift steps
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/mwrf_ifs.sv]
// Valid/ready channel interfaces: request, configuration write and frame byte.
`timescale 1ns / 1ps
interface mwrf_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  channel;
    logic [15:0] value_thousandths;
    modport source (output valid, command, channel, value_thousandths, input ready);
    modport sink   (input valid, command, channel, value_thousandths, output ready);
endinterface

interface mwrf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface mwrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

[rtl/core/mwrf_front.sv]
// Front end: configuration registers, request intake and header classification.
`timescale 1ns / 1ps
module mwrf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mwrf_req_if.sink       i_req,
    mwrf_cfg_if.sink       i_cfg,
    input  logic           i_q_full,
    output mwrf_pkg::t_q_push o_push
);
    import mwrf_pkg::*;

    logic [7:0] r_voltage_station;
    logic [7:0] r_current_station;
    logic [7:0] r_register_base;

    // Config writes always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_station <= VOLTAGE_STATION_RST;
            r_current_station <= CURRENT_STATION_RST;
            r_register_base   <= REGISTER_BASE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_VOLTAGE_STATION: r_voltage_station <= i_cfg.data;
                CFG_CURRENT_STATION: r_current_station <= i_cfg.data;
                CFG_REGISTER_BASE:   r_register_base   <= i_cfg.data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // Request goes straight into the queue when there is room
    assign i_req.ready = !i_q_full;

    always_comb begin
        o_push.valid        = i_req.valid && !i_q_full;
        o_push.hdr.station  = i_req.command ? r_current_station : r_voltage_station;
        o_push.hdr.reg_addr = r_register_base + i_req.channel;   // wraps mod 256
        o_push.hdr.value    = i_req.value_thousandths;
    end

endmodule

[rtl/core/mwrf_queue.sv]
// Small FIFO of classified frame headers between front and back end.
`timescale 1ns / 1ps
`include "modbus_write_register_framer_unit_macros.svh"
module mwrf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mwrf_pkg::t_q_push    i_push,
    output logic                 o_full,
    output logic                 o_valid,
    output mwrf_pkg::t_frame_hdr o_hdr,
    input  logic                 i_pop
);
    import mwrf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_hdr       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push, pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_hdr   = r_mem[r_rd_ptr];

    assign push = i_push.valid && !o_full;
    assign pop  = i_pop && o_valid;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        if (pop)  n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        if (push && !pop)      n_count = r_count + 1'b1;
        else if (pop && !push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push.hdr;
    end

    `MWRF_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "queue count over depth")
    `MWRF_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push.valid, !o_full, "front pushed into full queue")

endmodule

[rtl/core/mwrf_back.sv]
// Back end: walks the frame byte by byte, folds the CRC in and drives the output register.
`timescale 1ns / 1ps
`include "modbus_write_register_framer_unit_macros.svh"
module mwrf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  mwrf_pkg::t_frame_hdr i_q_hdr,
    output logic                 o_q_pop,
    mwrf_byte_if.source          o_out
);
    import mwrf_pkg::*;

    t_frame_pos  r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        load;
    logic [7:0]  byte_sel;
    logic        feed_crc;

    // Take the next byte when the output register is free or drains this cycle
    assign load    = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_q_pop = load && (r_pos == POS_CRC_HI);

    // Next position
    always_comb begin
        n_pos = r_pos;
        if (load) begin
            unique case (r_pos)
                POS_STATION: n_pos = POS_FUNC;
                POS_FUNC:    n_pos = POS_ADDR_HI;
                POS_ADDR_HI: n_pos = POS_ADDR_LO;
                POS_ADDR_LO: n_pos = POS_VAL_HI;
                POS_VAL_HI:  n_pos = POS_VAL_LO;
                POS_VAL_LO:  n_pos = POS_CRC_LO;
                POS_CRC_LO:  n_pos = POS_CRC_HI;
                POS_CRC_HI:  n_pos = POS_STATION;
            endcase
        end
    end

    // Byte for the current position; header bytes also feed the CRC
    always_comb begin
        feed_crc = 1'b1;
        unique case (r_pos)
            POS_STATION: byte_sel = i_q_hdr.station;
            POS_FUNC:    byte_sel = FUNC_WRITE_SINGLE;
            POS_ADDR_HI: byte_sel = REG_ADDR_HI;
            POS_ADDR_LO: byte_sel = i_q_hdr.reg_addr;
            POS_VAL_HI:  byte_sel = i_q_hdr.value[15:8];
            POS_VAL_LO:  byte_sel = i_q_hdr.value[7:0];
            POS_CRC_LO: begin
                byte_sel = r_crc[7:0];
                feed_crc = 1'b0;
            end
            POS_CRC_HI: begin
                byte_sel = r_crc[15:8];
                feed_crc = 1'b0;
            end
        endcase
    end

    // CRC accumulates one header byte per load, rearms after the last byte
    always_comb begin
        n_crc = r_crc;
        if (load) begin
            if (r_pos == POS_CRC_HI) n_crc = CRC_INIT;
            else if (feed_crc)       n_crc = crc_add_byte(r_crc, byte_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_STATION;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            if (load)              r_out_valid <= 1'b1;
            else if (o_out.ready)  r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= byte_sel;
            r_last <= (r_pos == POS_CRC_HI);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_byte;
    assign o_out.last_byte  = r_last;

    `MWRF_ASSERT_IMP(a_mid_frame_entry, i_clk, i_rst_n, r_pos != POS_STATION, i_q_valid, "queue entry lost mid-frame")
    `MWRF_ASSERT_NXT(a_crc_rearm, i_clk, i_rst_n, o_q_pop, r_crc == CRC_INIT, "CRC not rearmed after frame")
    `MWRF_ASSERT_IMP(a_last_at_wrap, i_clk, i_rst_n, r_out_valid && r_last, r_pos == POS_STATION, "last byte flagged off frame end")

endmodule

[rtl/core/modbus_write_register_framer_unit.sv]
// Each accepted set-output request yields one 8-byte Modbus RTU write-single-register
// frame (station, 0x06, 0x00, register, value high, value low, CRC low, CRC high) as
// eight transfers on the byte channel, the CRC high byte flagged last. The back end sends
// one frame byte per cycle while a request is queued and the output is not held by
// back-pressure, and folds each header byte into the CRC as it loads it. The first byte is
// presented once the request has passed the queue and the output register; up to QUEUE_DEPTH
// classified requests wait between front and back end, so requests are taken while a frame
// is still going out. Station addresses and register base are picked up at request transfer time.
`timescale 1ns / 1ps
module modbus_write_register_framer_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mwrf_req_if.sink     i_req,
    mwrf_cfg_if.sink     i_cfg,
    mwrf_byte_if.source  o_frame
);
    import mwrf_pkg::*;

    t_q_push    push;
    logic       q_full;
    logic       q_valid;
    t_frame_hdr q_hdr;
    logic       q_pop;

    mwrf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    mwrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_hdr   (q_hdr),
        .i_pop   (q_pop)
    );

    mwrf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_hdr   (q_hdr),
        .o_q_pop   (q_pop),
        .o_out     (o_frame)
    );

endmodule

[bench/tb_modbus_write_register_framer_unit.sv]
// Self-checking bench for the Modbus RTU write-single-register framer: random traffic and frame checks.
`timescale 1ns / 1ps
module tb_modbus_write_register_framer_unit;
    import mwrf_pkg::*;

    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned FRAME_BYTES   = 8;
    localparam int unsigned ITEMS_PER_SET = 48;
    localparam int unsigned LONG_HOLD     = 120;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned SETTLE_CYCLES = 8;
    // index 3 is not a register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic        command;
        logic [7:0]  channel;
        logic [15:0] value;
    } t_set_request;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_octet;

    logic i_clk;
    logic i_rst_n;

    mwrf_req_if  req_bus ();
    mwrf_cfg_if  cfg_bus ();
    mwrf_byte_if frame_bus ();

    modbus_write_register_framer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_frame (frame_bus)
    );

    // Bench copy of the station/base registers
    logic [7:0] voltage_station;
    logic [7:0] current_station;
    logic [7:0] register_base;

    t_set_request request_todo [$];
    t_frame_octet frame_expect [$];

    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned bytes_checked;
    int unsigned cfg_writes;
    int unsigned idle_cycles;

    logic req_taken;

    // Sender burst state
    t_set_request tx_item;
    logic         tx_valid;
    int unsigned  burst_left;
    int unsigned  gap_left;

    // Receiver stall state
    int unsigned rx_cycle;
    int unsigned rx_mode;
    int unsigned hold_cnt;
    logic        hold_trigger;
    logic        hold_done;
    logic        rx_ready;

    // Clock
    always begin
        i_clk = 1'b1;
        #(CLK_HALF);
        i_clk = 1'b0;
        #(CLK_HALF);
    end

    // One byte into CRC-16/Modbus, LSB first
    function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 16'hA001;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Expected frame for one request under the current register copy
    function automatic void predict_frame(input t_set_request r);
        logic [7:0]   hdr [6];
        logic [15:0]  crc;
        t_frame_octet o;
        hdr[0] = r.command ? current_station : voltage_station;
        hdr[1] = 8'h06;
        hdr[2] = 8'h00;
        hdr[3] = register_base + r.channel;
        hdr[4] = r.value[15:8];
        hdr[5] = r.value[7:0];
        crc = 16'hFFFF;
        for (int i = 0; i < 6; i++) begin
            crc = fold_crc_byte(crc, hdr[i]);
            o.frame_byte = hdr[i];
            o.last_byte  = 1'b0;
            frame_expect.push_back(o);
        end
        o.frame_byte = crc[7:0];
        o.last_byte  = 1'b0;
        frame_expect.push_back(o);
        o.frame_byte = crc[15:8];
        o.last_byte  = 1'b1;
        frame_expect.push_back(o);
    endfunction

    // Monitor: predict on request transfer, track config, check frame bytes
    always @(posedge i_clk) begin
        t_set_request r;
        t_frame_octet want;
        logic         active;
        active    = 1'b0;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                r.command = req_bus.command;
                r.channel = req_bus.channel;
                r.value   = req_bus.value_thousandths;
                predict_frame(r);
                requests_sent++;
                req_taken = 1'b1;
                active    = 1'b1;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_VOLTAGE_STATION: voltage_station = cfg_bus.data;
                    CFG_CURRENT_STATION: current_station = cfg_bus.data;
                    CFG_REGISTER_BASE:   register_base   = cfg_bus.data;
                    default: ;
                endcase
                cfg_writes++;
                active = 1'b1;
            end
            if (frame_bus.valid && frame_bus.ready) begin
                active = 1'b1;
                if (frame_expect.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected frame byte %02h last %0b", $time,
                             frame_bus.frame_byte, frame_bus.last_byte);
                end else begin
                    want = frame_expect.pop_front();
                    bytes_checked++;
                    if (frame_bus.frame_byte !== want.frame_byte) begin
                        error_count++;
                        $display("%0t: frame_byte expected %02h actual %02h", $time,
                                 want.frame_byte, frame_bus.frame_byte);
                    end
                    if (frame_bus.last_byte !== want.last_byte) begin
                        error_count++;
                        $display("%0t: last_byte expected %0b actual %0b", $time,
                                 want.last_byte, frame_bus.last_byte);
                    end
                end
            end
            // watchdog on cycles with no transfer at all
            idle_cycles = active ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("FAIL modbus_write_register_framer_unit");
                $finish;
            end
        end
    end

    // Request driver: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid = 1'b0;
        end else begin
            tx_valid = req_bus.valid && !req_taken;
            if (!tx_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_todo.size() > 0) begin
                    tx_item  = request_todo.pop_front();
                    tx_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        req_bus.valid             <= tx_valid;
        req_bus.command           <= tx_item.command;
        req_bus.channel           <= tx_item.channel;
        req_bus.value_thousandths <= tx_item.value;
    end

    // Frame receiver: stall pattern re-picked at random, plus one long hold
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        if (hold_trigger && !hold_done) begin
            rx_ready = 1'b0;
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD) begin
                hold_done = 1'b1;
            end
        end else begin
            case (rx_mode)
                0: rx_ready = 1'b1;
                1: rx_ready = ($urandom_range(0, 3) != 0);
                2: rx_ready = ($urandom_range(0, 9) < 3);
                default: rx_ready = (rx_cycle % 5 != 0);
            endcase
        end
        frame_bus.ready <= rx_ready;
    end

    task automatic queue_request(input logic cmd, input logic [7:0] chan,
                                 input logic [15:0] val);
        t_set_request r;
        r.command = cmd;
        r.channel = chan;
        r.value   = val;
        request_todo.push_back(r);
    endtask

    task automatic queue_random_requests(input int unsigned count);
        for (int i = 0; i < count; i++) begin
            // every so often aim at the register address wrap
            if ($urandom_range(0, 4) == 0) begin
                queue_request(1'($urandom_range(0, 1)), 8'($urandom_range(230, 255)),
                              16'($urandom_range(0, 65535)));
            end else begin
                queue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic program_stations(input logic [7:0] volt, input logic [7:0] curr,
                                    input logic [7:0] base);
        write_register(CFG_VOLTAGE_STATION, volt);
        write_register(CFG_CURRENT_STATION, curr);
        write_register(CFG_REGISTER_BASE, base);
    endtask

    // Block is idle once nothing is queued, offered or owed; checked at the
    // rising edge so the driver's falling-edge update has settled
    task automatic wait_idle();
        @(posedge i_clk);
        while (request_todo.size() != 0 || req_bus.valid || frame_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n                   = 1'b0;
        req_bus.valid             = 1'b0;
        req_bus.command           = 1'b0;
        req_bus.channel           = 8'h00;
        req_bus.value_thousandths = 16'h0000;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = CFG_VOLTAGE_STATION;
        cfg_bus.data              = 8'h00;
        frame_bus.ready           = 1'b0;
        voltage_station = VOLTAGE_STATION_RST;
        current_station = CURRENT_STATION_RST;
        register_base   = REGISTER_BASE_RST;
        tx_item         = '0;
        tx_valid        = 1'b0;
        burst_left      = 0;
        gap_left        = 0;
        rx_cycle        = 0;
        rx_mode         = 0;
        hold_cnt        = 0;
        hold_trigger    = 1'b0;
        hold_done       = 1'b0;
        req_taken       = 1'b0;
        error_count     = 0;
        requests_sent   = 0;
        bytes_checked   = 0;
        cfg_writes      = 0;
        idle_cycles     = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset stations, field extremes, both commands, address wrap
        queue_request(1'b0, 8'h00, 16'h0000);
        queue_request(1'b1, 8'h00, 16'h0000);
        queue_request(1'b0, 8'hFF, 16'hFFFF);
        queue_request(1'b1, 8'hFF, 16'hFFFF);
        queue_request(1'b0, 8'hEA, 16'h8000);
        queue_request(1'b1, 8'hEB, 16'h0001);
        queue_request(1'b0, 8'hAA, 16'hAAAA);
        queue_request(1'b1, 8'h55, 16'h5555);
        queue_request(1'b0, 8'h01, 16'h00FF);
        queue_request(1'b1, 8'h80, 16'hFF00);
        queue_request(1'b0, 8'h7F, 16'h1388);
        queue_request(1'b1, 8'h03, 16'h03E8);
        wait_idle();

        // All-zero registers; the unused index must not disturb anything
        program_stations(8'h00, 8'h00, 8'h00);
        write_register(CFG_UNUSED_IDX, 8'hFF);
        queue_request(1'b0, 8'hFF, 16'hFFFF);
        queue_request(1'b1, 8'h00, 16'h0000);
        queue_random_requests(ITEMS_PER_SET);
        wait_idle();

        // All-ones registers
        program_stations(8'hFF, 8'hFF, 8'hFF);
        write_register(CFG_UNUSED_IDX, 8'h00);
        queue_request(1'b0, 8'h01, 16'h1234);
        queue_request(1'b1, 8'hFF, 16'hFEDC);
        queue_random_requests(ITEMS_PER_SET);
        wait_idle();

        program_stations(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        queue_random_requests(ITEMS_PER_SET);
        wait_idle();

        // Back-pressure: receiver holds off while requests keep coming
        program_stations(8'hFF, 8'h00, 8'hC8);
        hold_trigger = 1'b1;
        queue_random_requests(ITEMS_PER_SET);
        wait_idle();

        program_stations(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        queue_random_requests(ITEMS_PER_SET);
        wait_idle();

        // Back to the power-on settings
        program_stations(VOLTAGE_STATION_RST, CURRENT_STATION_RST, REGISTER_BASE_RST);
        queue_random_requests(ITEMS_PER_SET);
        wait_idle();

        $display("Covered %0d requests, %0d frame bytes checked, %0d config writes",
                 requests_sent, bytes_checked, cfg_writes);
        $display("Station/base settings at zero, all-ones, random and power-on values");
        if (error_count == 0 && frame_expect.size() == 0) begin
            $display("PASS modbus_write_register_framer_unit");
        end else begin
            $display("%0d mismatches, %0d frame bytes still owed", error_count,
                     frame_expect.size());
            $display("FAIL modbus_write_register_framer_unit");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mwrf_pkg.sv
rtl/core/mwrf_ifs.sv
rtl/core/mwrf_front.sv
rtl/core/mwrf_queue.sv
rtl/core/mwrf_back.sv
rtl/core/modbus_write_register_framer_unit.sv
bench/tb_modbus_write_register_framer_unit.sv
